/* design/rhb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhb_pkg
// Shared types and constants of the rgb555 histogram binner: bin store
// geometry, item kinds and the controller to datapath command and status.
// ----------------------------------------------------------------------------
package rhb_pkg;

    localparam int BIN_AW    = 15;
    localparam int BIN_COUNT = 1 << BIN_AW;
    localparam int DATA_W    = 16;
    localparam int CHAN_W    = 16;
    localparam int CHAN_BITS = 5;

    localparam logic [BIN_AW-1:0] BLACK_BIN    = '0;
    localparam logic [BIN_AW-1:0] WHITE_BIN    = '1;
    localparam logic [DATA_W-1:0] DISTINCT_MAX = 16'd32768;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_READ   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ADDR_ITEM,
        ADDR_BLACK,
        ADDR_WHITE,
        ADDR_READ
    } addr_sel_t;

    typedef struct packed {
        logic      capture;
        addr_sel_t addr_sel;
        logic      rd_en;
        logic      accum;
        logic      drop;
        logic      read_load;
        logic      clear_we;
        logic      count_clear;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic fin;
        logic clear_done;
    } status_t;

endpackage : rhb_pkg
`default_nettype wire

/* design/rhb_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhb_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rhb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : rhb_ram
`default_nettype wire

/* design/rhb_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhb_datapath
// Item registers, bin store, clear sweep counter, distinct bin counter and
// the result registers.
// ----------------------------------------------------------------------------
module rhb_datapath
    import rhb_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  cmd_t               cmd,
    output status_t            st,
    input  wire                cfg_valid,
    input  wire                cfg_data,
    input  wire  [1:0]         kind,
    input  wire  [CHAN_W-1:0]  color_red,
    input  wire  [CHAN_W-1:0]  color_green,
    input  wire  [CHAN_W-1:0]  color_blue,
    input  wire  [DATA_W-1:0]  pixel_count,
    input  wire                last_color,
    input  wire  [BIN_AW-1:0]  bin_index,
    output logic [DATA_W-1:0]  distinct_bins,
    output logic [DATA_W-1:0]  bin_value,
    output logic               finished
);

    logic              suppress_reg;
    logic [BIN_AW-1:0] clr_addr_reg;
    logic [DATA_W-1:0] count_reg;
    logic [BIN_AW-1:0] idx_reg;
    logic [BIN_AW-1:0] rd_idx_reg;
    logic [DATA_W-1:0] cnt_reg;
    logic              fin_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] distinct_out_reg;
    logic [DATA_W-1:0] value_out_reg;
    logic              fin_out_reg;

    logic [BIN_AW-1:0] addr;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] sum;
    logic              old_zero;
    logic              drop_hit;
    logic              ram_we;
    logic [BIN_AW-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_ITEM:  addr = idx_reg;
            ADDR_BLACK: addr = BLACK_BIN;
            ADDR_WHITE: addr = WHITE_BIN;
            ADDR_READ:  addr = rd_idx_reg;
            default:    addr = idx_reg;
        endcase
    end

    assign sum       = rdata + cnt_reg;
    assign old_zero  = (rdata == '0);
    assign drop_hit  = cmd.drop && !old_zero;
    assign ram_we    = cmd.clear_we || cmd.accum || drop_hit;
    assign ram_waddr = cmd.clear_we ? clr_addr_reg : addr;
    assign ram_wdata = cmd.accum ? sum : '0;

    rhb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (addr),
        .rdata (rdata)
    );

    assign st.fin        = fin_reg;
    assign st.clear_done = (clr_addr_reg == WHITE_BIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            suppress_reg <= 1'b0;
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                suppress_reg <= cfg_data;
            end
            if (cmd.clear_we)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            // saturating distinct bin count
            if (cmd.count_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.accum && old_zero && count_reg < DISTINCT_MAX)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (drop_hit && count_reg != '0)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg    <= {color_red[CHAN_W-1 -: CHAN_BITS],
                           color_green[CHAN_W-1 -: CHAN_BITS],
                           color_blue[CHAN_W-1 -: CHAN_BITS]};
            rd_idx_reg <= bin_index;
            cnt_reg    <= pixel_count;
            fin_reg    <= (kind_t'(kind) == KIND_ADD) && last_color && suppress_reg;
            value_reg  <= '0;
        end
        else if (cmd.accum)
        begin
            value_reg <= sum;
        end
        else if (cmd.read_load)
        begin
            value_reg <= rdata;
        end
        else if (drop_hit && addr == idx_reg)
        begin
            // the added bin itself was black or white
            value_reg <= '0;
        end
        if (cmd.out_load)
        begin
            distinct_out_reg <= count_reg;
            value_out_reg    <= value_reg;
            fin_out_reg      <= fin_reg;
        end
    end

    assign distinct_bins = distinct_out_reg;
    assign bin_value     = value_out_reg;
    assign finished      = fin_out_reg;

endmodule : rhb_datapath
`default_nettype wire

/* design/rhb_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhb_ctrl
// Sequencer: steps each item through its bin store reads and writes, runs
// the clear sweep and hands the result to the output register.
// ----------------------------------------------------------------------------
module rhb_ctrl
    import rhb_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  kind,
    output logic        out_valid,
    input  wire         out_ready,
    output cmd_t        cmd,
    input  status_t     st
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_ADD_RD,
        S_ADD_WR,
        S_BLK_RD,
        S_BLK_WR,
        S_WHT_RD,
        S_WHT_WR,
        S_RD_RD,
        S_RD_DATA,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   from_item_reg;
    logic   from_item_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.addr_sel   = ADDR_ITEM;
        state_next     = state_reg;
        from_item_next = from_item_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (kind_t'(kind))
                        KIND_CLEAR:
                        begin
                            cmd.count_clear = 1'b1;
                            from_item_next  = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        KIND_ADD:  state_next = S_ADD_RD;
                        KIND_READ: state_next = S_RD_RD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (st.clear_done)
                begin
                    state_next = from_item_reg ? S_DONE : S_IDLE;
                end
            end
            S_ADD_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.accum  = 1'b1;
                state_next = st.fin ? S_BLK_RD : S_DONE;
            end
            S_BLK_RD:
            begin
                cmd.addr_sel = ADDR_BLACK;
                cmd.rd_en    = 1'b1;
                state_next   = S_BLK_WR;
            end
            S_BLK_WR:
            begin
                cmd.addr_sel = ADDR_BLACK;
                cmd.drop     = 1'b1;
                state_next   = S_WHT_RD;
            end
            S_WHT_RD:
            begin
                cmd.addr_sel = ADDR_WHITE;
                cmd.rd_en    = 1'b1;
                state_next   = S_WHT_WR;
            end
            S_WHT_WR:
            begin
                cmd.addr_sel = ADDR_WHITE;
                cmd.drop     = 1'b1;
                state_next   = S_DONE;
            end
            S_RD_RD:
            begin
                cmd.addr_sel = ADDR_READ;
                cmd.rd_en    = 1'b1;
                state_next   = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                cmd.read_load = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                // hold here while the previous result is still untaken
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            from_item_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            from_item_reg <= (state_reg == S_CLEAR && st.clear_done) ? 1'b0 : from_item_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule : rhb_ctrl
`default_nettype wire

/* design/rgb555_histogram_binner.sv */
`default_nettype none
// Per item: a read looks up one bin, an add updates one bin and, with
// suppression on the last color, also drops the black and white bins.
// One item at a time: the next input transfer is taken only once the result
// of the last item is loaded, paced by the single port pair of the bin store.
// After reset a clearing pass zeroes all 32768 bins; no item is
// taken during it, configuration writes are.
// ----------------------------------------------------------------------------
// rgb555_histogram_binner
// 5-5-5 color histogram over 32768 bins with a saturating count of occupied
// bins and optional black and white removal after the last add.
// ----------------------------------------------------------------------------
module rgb555_histogram_binner
    import rhb_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire                cfg_data,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [1:0]         kind,
    input  wire  [CHAN_W-1:0]  color_red,
    input  wire  [CHAN_W-1:0]  color_green,
    input  wire  [CHAN_W-1:0]  color_blue,
    input  wire  [DATA_W-1:0]  pixel_count,
    input  wire                last_color,
    input  wire  [BIN_AW-1:0]  bin_index,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [DATA_W-1:0]  distinct_bins,
    output logic [DATA_W-1:0]  bin_value,
    output logic               finished
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    rhb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    rhb_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .color_red     (color_red),
        .color_green   (color_green),
        .color_blue    (color_blue),
        .pixel_count   (pixel_count),
        .last_color    (last_color),
        .bin_index     (bin_index),
        .distinct_bins (distinct_bins),
        .bin_value     (bin_value),
        .finished      (finished)
    );

endmodule : rgb555_histogram_binner
`default_nettype wire
